### hw/rtl/assert_macros.svh
// assertion helpers for the rtl, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MER_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define MER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hw/rtl/mer_pkg.sv
package mer_pkg;

  // field reading width
  localparam int SAMPLE_WIDTH = 24;

  localparam int NREG  = 16;
  localparam int PTR_W = 4;

  typedef logic [PTR_W-1:0]               reg_idx_t;
  typedef logic [7:0]                     byte_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // transaction kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // register indexes
  localparam reg_idx_t IDX_WIA1       = 4'd0;
  localparam reg_idx_t IDX_WIA2       = 4'd1;
  localparam reg_idx_t IDX_ST1        = 4'd4;
  localparam reg_idx_t IDX_DATA0      = 4'd5;
  localparam reg_idx_t IDX_DATA_LAST  = 4'd11;
  localparam reg_idx_t IDX_ST2        = 4'd12;
  localparam reg_idx_t IDX_CTRL_FIRST = 4'd13;
  localparam reg_idx_t IDX_CNTL2      = 4'd14;

  localparam byte_t WIA1_RESET = 8'h48;
  localparam byte_t WIA2_RESET = 8'h09;

  // status bits
  localparam byte_t ST1_DRDY = 8'h01;
  localparam byte_t ST1_DOR  = 8'h02;
  localparam byte_t ST2_HOFL = 8'h08;

  // measurement modes, low five bits of cntl2
  localparam logic [4:0] MODE_SINGLE = 5'h01;
  localparam logic [4:0] MODE_DIV10  = 5'h02;
  localparam logic [4:0] MODE_DIV5   = 5'h04;
  localparam logic [4:0] MODE_DIV2   = 5'h06;
  localparam logic [4:0] MODE_EVERY  = 5'h08;

  localparam logic [3:0] RATE_LAST = 4'd9;

  // scaling: 32752/49120 reduces to 2047/3070
  localparam int MAG_W       = 17;
  localparam int GAIN_W      = 11;
  localparam int PROD1_W     = MAG_W + GAIN_W;
  localparam int DEN_LOG2    = 12;
  localparam int RECIP_SHIFT = PROD1_W + DEN_LOG2;
  localparam int RECIP_W     = 29;
  localparam int PROD2_W     = PROD1_W + RECIP_W;
  localparam logic [GAIN_W-1:0] GAIN_NUM = 11'd2047;
  localparam longint GAIN_DEN = 3070;
  // ceiling reciprocal, exact quotient for every dividend below 2**PROD1_W
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + GAIN_DEN - 1) / GAIN_DEN);
  localparam logic [15:0] CLAMP_LIM = 16'd32752;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  // bus address of each map entry
  function automatic byte_t map_addr(input reg_idx_t idx);
    byte_t a;
    unique case (idx)
      4'd0:    a = 8'h00;
      4'd1:    a = 8'h01;
      4'd2:    a = 8'h02;
      4'd3:    a = 8'h03;
      4'd4:    a = 8'h10;
      4'd5:    a = 8'h11;
      4'd6:    a = 8'h12;
      4'd7:    a = 8'h13;
      4'd8:    a = 8'h14;
      4'd9:    a = 8'h15;
      4'd10:   a = 8'h16;
      4'd11:   a = 8'h17;
      4'd12:   a = 8'h18;
      4'd13:   a = 8'h30;
      4'd14:   a = 8'h31;
      default: a = 8'h32;
    endcase
    return a;
  endfunction

  // auto-increment chain
  function automatic reg_idx_t map_next(input reg_idx_t idx);
    reg_idx_t n;
    priority if (idx == IDX_ST2)   n = IDX_WIA1;
    else if (idx == 4'd15)         n = IDX_CTRL_FIRST;
    else                           n = idx + 4'd1;
    return n;
  endfunction

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       mul1;
    logic       mul2;
    logic       wr;
    logic       finish;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic tick_upd;
  } status_t;

endpackage

### hw/rtl/magnetometer_register_emulator.sv
// magnetometer register map emulation, 16 registers behind an i2c-style byte interface
// input channel: a transaction is taken at a rising edge with start high and busy low;
//   in_req_type selects byte received (in_first_byte marks the register address),
//   byte requested, or sample tick carrying in_sample_x/y/z and in_overflow
// result channel: every transaction returns one byte on out_rdata, valid for exactly
//   one cycle while out_valid is high; zero unless the transaction was a read
// timing: a byte transaction keeps busy high only in the exec state; out_valid follows in
//   the next cycle, once the controller is back in idle
// a tick that updates the data registers runs the shared scaling unit three times,
//   once per axis, in the order gain multiply, reciprocal multiply, clamp and write;
//   busy stays high through all of it; other ticks finish like byte transactions
// a new transaction may be accepted in the cycle its predecessor's result is shown
// the receiver has no way to stall the result strobe
// reset: synchronous, active low; the map returns to 0x48, 0x09 and zeros, pointer at
//   the first register, data lock and rate divider cleared
module magnetometer_register_emulator (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_req_type,
  input  logic             in_first_byte,
  input  mer_pkg::byte_t   in_wdata,
  input  mer_pkg::sample_t in_sample_x,
  input  mer_pkg::sample_t in_sample_y,
  input  mer_pkg::sample_t in_sample_z,
  input  logic             in_overflow,
  output logic             out_valid,
  output mer_pkg::byte_t   out_rdata
);
  import mer_pkg::*;

  `include "assert_macros.svh"

  // sequencing commands and the tick decision back from the datapath
  cmd_t    cmd;
  status_t status;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  // register map, pointer, lock, rate divider and the scaling unit
  mer_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req_type   (in_req_type),
    .in_first_byte (in_first_byte),
    .in_wdata      (in_wdata),
    .in_sample_x   (in_sample_x),
    .in_sample_y   (in_sample_y),
    .in_sample_z   (in_sample_z),
    .in_overflow   (in_overflow),
    .cmd           (cmd),
    .status        (status),
    .out_rdata     (out_rdata)
  );

  // result only shows once the controller is back to idle
  `MER_ASSERT_NOW(a_valid_idle, clk, rst_n, out_valid, !busy)
  // an accepted transaction always occupies the block the next cycle
  `MER_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // one result per transaction, never back to back
  `MER_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  // at most one datapath step per cycle
  `MER_ASSERT_NOW(a_one_step, clk, rst_n, 1'b1,
                  $onehot0({cmd.load, cmd.exec, cmd.mul1, cmd.mul2, cmd.wr}))

endmodule

### hw/rtl/mer_ctrl.sv
module mer_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  input  mer_pkg::status_t status,
  output mer_pkg::cmd_t    cmd
);
  import mer_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_MUL1 = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_WR   = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    cmd.axis  = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.tick_upd) begin
          axis_nxt  = 2'd0;
          state_nxt = ST_MUL1;
        end else begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        if (axis_r == AXIS_LAST) begin
          cmd.finish = 1'b1;
          valid_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_MUL1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;

endmodule

### hw/rtl/mer_datapath.sv
module mer_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       in_req_type,
  input  logic             in_first_byte,
  input  mer_pkg::byte_t   in_wdata,
  input  mer_pkg::sample_t in_sample_x,
  input  mer_pkg::sample_t in_sample_y,
  input  mer_pkg::sample_t in_sample_z,
  input  logic             in_overflow,
  input  mer_pkg::cmd_t    cmd,
  output mer_pkg::status_t status,
  output mer_pkg::byte_t   out_rdata
);
  import mer_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  // latched transaction
  logic [1:0] req_r;
  logic       first_r;
  byte_t      wdata_r;
  sample_t    sx_r, sy_r, sz_r;
  logic       ovf_r;

  // register map and control state
  byte_t      regs_r [NREG];
  byte_t      regs_nxt [NREG];
  reg_idx_t   ptr_r, ptr_nxt;
  logic       lock_r, lock_nxt;
  logic [3:0] rate_r, rate_nxt;
  byte_t      rdata_r, rdata_nxt;

  // scaling pipeline
  logic [PROD1_W-1:0] m1_r, m1_nxt;
  logic [MAG_W-1:0]   q_r, q_nxt;
  logic               neg1_r, neg1_nxt, neg2_r, neg2_nxt;

  logic [4:0]         mode;
  logic               rate_hit;
  logic signed [SW:0] s_sel;
  logic [SW:0]        mag;
  logic [MAG_W-1:0]   mag_sat;
  logic [PROD2_W-1:0] prod;
  logic [15:0]        q_clamp, q_val;
  reg_idx_t           lo_idx, hi_idx;

  assign mode = regs_r[IDX_CNTL2][4:0];

  always_comb begin
    unique case (mode)
      MODE_SINGLE, MODE_EVERY: rate_hit = 1'b1;
      MODE_DIV10:              rate_hit = (rate_r == 4'd0);
      MODE_DIV5:               rate_hit = (rate_r == 4'd0) || (rate_r == 4'd5);
      MODE_DIV2:               rate_hit = !rate_r[0];
      default:                 rate_hit = 1'b0;
    endcase
  end

  assign status.tick_upd = (req_r == KIND_TICK) && rate_hit && !lock_r;

  // axis select, y and z mirrored
  always_comb begin
    unique case (cmd.axis)
      2'd0:    s_sel = {sx_r[SW-1], sx_r};
      2'd1:    s_sel = -{sy_r[SW-1], sy_r};
      default: s_sel = -{sz_r[SW-1], sz_r};
    endcase
    mag     = s_sel[SW] ? -s_sel : s_sel;
    // anything this large clamps anyway
    mag_sat = (|mag[SW:MAG_W]) ? {MAG_W{1'b1}} : mag[MAG_W-1:0];
  end

  assign prod    = PROD2_W'(m1_r) * PROD2_W'(RECIP);
  assign q_clamp = (q_r > MAG_W'(CLAMP_LIM)) ? CLAMP_LIM : q_r[15:0];
  assign q_val   = neg2_r ? -q_clamp : q_clamp;
  assign lo_idx  = IDX_DATA0 + reg_idx_t'({cmd.axis, 1'b0});
  assign hi_idx  = lo_idx + 4'd1;

  always_comb begin
    regs_nxt  = regs_r;
    ptr_nxt   = ptr_r;
    lock_nxt  = lock_r;
    rate_nxt  = rate_r;
    rdata_nxt = rdata_r;
    m1_nxt    = m1_r;
    q_nxt     = q_r;
    neg1_nxt  = neg1_r;
    neg2_nxt  = neg2_r;

    if (cmd.exec) begin
      rdata_nxt = '0;
      unique case (req_r)
        KIND_WRITE: begin
          if (first_r) begin
            for (int i = 0; i < NREG; i++) begin
              if (map_addr(reg_idx_t'(i)) == wdata_r) ptr_nxt = reg_idx_t'(i);
            end
          end else begin
            if (ptr_r >= IDX_CTRL_FIRST) regs_nxt[ptr_r] = wdata_r;
            ptr_nxt = map_next(ptr_r);
          end
        end
        KIND_READ: begin
          if (ptr_r >= IDX_DATA0 && ptr_r <= IDX_DATA_LAST &&
              (regs_r[IDX_ST1] & ST1_DRDY) != 8'h00) begin
            lock_nxt          = 1'b1;
            regs_nxt[IDX_ST1] = regs_r[IDX_ST1] & ~(ST1_DRDY | ST1_DOR);
          end
          if (ptr_r == IDX_ST2) lock_nxt = 1'b0;
          rdata_nxt = regs_r[ptr_r];
          ptr_nxt   = map_next(ptr_r);
        end
        KIND_TICK: begin
          if (lock_r) regs_nxt[IDX_ST1] = regs_r[IDX_ST1] | ST1_DOR;
          rate_nxt = (rate_r == RATE_LAST) ? 4'd0 : rate_r + 4'd1;
        end
        default: ;
      endcase
    end

    if (cmd.mul1) begin
      m1_nxt   = PROD1_W'(mag_sat) * PROD1_W'(GAIN_NUM);
      neg1_nxt = s_sel[SW];
    end

    if (cmd.mul2) begin
      q_nxt    = prod[PROD2_W-1:RECIP_SHIFT];
      neg2_nxt = neg1_r;
    end

    if (cmd.wr) begin
      regs_nxt[lo_idx] = q_val[7:0];
      regs_nxt[hi_idx] = q_val[15:8];
    end

    if (cmd.finish) begin
      regs_nxt[IDX_ST1] = regs_r[IDX_ST1] | ST1_DRDY;
      if (ovf_r) regs_nxt[IDX_ST2] = regs_r[IDX_ST2] | ST2_HOFL;
      if (mode == MODE_SINGLE) regs_nxt[IDX_CNTL2] = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) begin
        if (reg_idx_t'(i) == IDX_WIA1)      regs_r[i] <= WIA1_RESET;
        else if (reg_idx_t'(i) == IDX_WIA2) regs_r[i] <= WIA2_RESET;
        else                                regs_r[i] <= 8'h00;
      end
      ptr_r            <= IDX_WIA1;
      lock_r           <= 1'b0;
      rate_r           <= 4'd0;
    end else begin
      regs_r <= regs_nxt;
      ptr_r  <= ptr_nxt;
      lock_r <= lock_nxt;
      rate_r <= rate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      first_r <= in_first_byte;
      wdata_r <= in_wdata;
      sx_r    <= in_sample_x;
      sy_r    <= in_sample_y;
      sz_r    <= in_sample_z;
      ovf_r   <= in_overflow;
    end
    rdata_r <= rdata_nxt;
    m1_r    <= m1_nxt;
    q_r     <= q_nxt;
    neg1_r  <= neg1_nxt;
    neg2_r  <= neg2_nxt;
  end

  assign out_rdata = rdata_r;

endmodule

### test/tb_top.sv
// testbench for the magnetometer register map emulator
module tb_top;
  import mer_pkg::*;

  // run shape
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction on either side
  localparam int SETTLE_CYCLES  = 30;    // quiet time after the last result
  localparam int RANDOM_XACTS   = 1500;

  // request kind that the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // last map entry, the one after cntl2 in the control chain
  localparam reg_idx_t IDX_CTRL_LAST = 4'd15;

  // bus addresses used by the stimulus
  localparam byte_t ADDR_WIA1     = 8'h00;
  localparam byte_t ADDR_ST1      = 8'h10;
  localparam byte_t ADDR_DATA0    = 8'h11;
  localparam byte_t ADDR_ST2      = 8'h18;
  localparam byte_t ADDR_CTRL_A   = 8'h30;
  localparam byte_t ADDR_CNTL2    = 8'h31;
  localparam byte_t ADDR_CTRL_C   = 8'h32;
  localparam byte_t ADDR_UNMAPPED = 8'hFF;

  // axis scaling, full scale 49120 in maps to 32752 out
  localparam longint AXIS_GAIN_NUM = 32752;
  localparam longint AXIS_GAIN_DEN = 49120;
  localparam longint AXIS_LIMIT    = 32752;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // one transaction on the input channel
  typedef struct {
    logic [1:0] kind;
    logic       first;
    byte_t      wdata;
    sample_t    sx;
    sample_t    sy;
    sample_t    sz;
    logic       ovf;
    logic       drain;  // hold off until every result so far has come back
  } xact_t;

  // dut signals, the inputs all known from time zero
  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       start         = 1'b0;
  logic       busy;
  logic [1:0] in_req_type   = KIND_WRITE;
  logic       in_first_byte = 1'b0;
  byte_t      in_wdata      = '0;
  sample_t    in_sample_x   = '0;
  sample_t    in_sample_y   = '0;
  sample_t    in_sample_z   = '0;
  logic       in_overflow   = 1'b0;
  logic       out_valid;
  byte_t      out_rdata;

  magnetometer_register_emulator u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_first_byte(in_first_byte),
    .in_wdata     (in_wdata),
    .in_sample_x  (in_sample_x),
    .in_sample_y  (in_sample_y),
    .in_sample_z  (in_sample_z),
    .in_overflow  (in_overflow),
    .out_valid    (out_valid),
    .out_rdata    (out_rdata)
  );

  always #5 clk = ~clk;

  // stimulus and expected read bytes
  xact_t pending_xacts[$];
  byte_t expected_bytes[$];
  logic  drain_next = 1'b0;

  // shadow copy of the register map
  byte_t      map_regs [NREG];
  reg_idx_t   map_ptr;
  logic       map_locked;
  logic [3:0] tick_phase;

  // bookkeeping
  int n_accepted = 0;
  int n_results  = 0;   // written with nonblocking assignments only
  int n_errors   = 0;
  int n_reads    = 0;
  int n_writes   = 0;
  int n_ticks    = 0;
  int n_updates  = 0;
  int n_locks    = 0;
  int n_overruns = 0;

  // sender burst shaping
  int   gap_left   = 0;
  int   burst_left = 0;
  int   stall_cycles = 0;
  xact_t cur_xact;

  // bus address of a map entry: 0x00-0x03, then 0x10-0x18, then 0x30-0x32
  function automatic byte_t bus_addr(input reg_idx_t idx);
    if (idx < IDX_ST1) return byte_t'(idx);
    if (idx <= IDX_ST2) return ADDR_ST1 + byte_t'(idx - IDX_ST1);
    return ADDR_CTRL_A + byte_t'(idx - IDX_CTRL_FIRST);
  endfunction

  // pointer chain: wraps at st2 back to the first register, control regs loop among themselves
  function automatic reg_idx_t chain_next(input reg_idx_t idx);
    if (idx == IDX_ST2) return IDX_WIA1;
    if (idx == IDX_CTRL_LAST) return IDX_CTRL_FIRST;
    return idx + 4'd1;
  endfunction

  // scale, truncate toward zero, clamp, keep 16 bits
  function automatic logic [15:0] scale_axis(input longint v);
    longint q;
    q = (v * AXIS_GAIN_NUM) / AXIS_GAIN_DEN;
    if (q > AXIS_LIMIT) q = AXIS_LIMIT;
    else if (q < -AXIS_LIMIT) q = -AXIS_LIMIT;
    return q[15:0];
  endfunction

  // apply one transaction to the shadow map and give the byte it returns
  task automatic apply_xact(input xact_t t, output byte_t rd);
    logic [4:0]  mode;
    logic        upd;
    logic [15:0] ax [3];
    rd = '0;
    case (t.kind)
      KIND_WRITE: begin
        n_writes++;
        if (t.first) begin
          // address byte, an unmapped one leaves the pointer alone
          for (int i = NREG - 1; i >= 0; i--)
            if (bus_addr(reg_idx_t'(i)) == t.wdata) map_ptr = reg_idx_t'(i);
        end else begin
          // only the control registers take data, the pointer moves on regardless
          if (map_ptr >= IDX_CTRL_FIRST) map_regs[map_ptr] = t.wdata;
          map_ptr = chain_next(map_ptr);
        end
      end
      KIND_READ: begin
        n_reads++;
        if (map_ptr >= IDX_DATA0 && map_ptr <= IDX_DATA_LAST &&
            (map_regs[IDX_ST1] & ST1_DRDY) != '0) begin
          map_locked = 1'b1;
          map_regs[IDX_ST1] &= ~(ST1_DRDY | ST1_DOR);
          n_locks++;
        end
        if (map_ptr == IDX_ST2) map_locked = 1'b0;
        rd = map_regs[map_ptr];
        map_ptr = chain_next(map_ptr);
      end
      KIND_TICK: begin
        n_ticks++;
        mode = map_regs[IDX_CNTL2][4:0];
        case (mode)
          MODE_SINGLE, MODE_EVERY: upd = 1'b1;
          MODE_DIV10:              upd = (tick_phase == 4'd0);
          MODE_DIV5:               upd = (tick_phase % 5 == 0);
          MODE_DIV2:               upd = (tick_phase[0] == 1'b0);
          default:                 upd = 1'b0;
        endcase
        // a locked data set is protected, the lost sample shows as overrun
        if (map_locked) begin
          map_regs[IDX_ST1] |= ST1_DOR;
          upd = 1'b0;
          n_overruns++;
        end
        if (upd) begin
          n_updates++;
          ax[0] = scale_axis(longint'(t.sx));
          ax[1] = scale_axis(-longint'(t.sy));
          ax[2] = scale_axis(-longint'(t.sz));
          for (int k = 0; k < 3; k++) begin
            map_regs[IDX_DATA0 + 2*k]     = ax[k][7:0];
            map_regs[IDX_DATA0 + 2*k + 1] = ax[k][15:8];
          end
          if (t.ovf) map_regs[IDX_ST2] |= ST2_HOFL;
          map_regs[IDX_ST1] |= ST1_DRDY;
          if (mode == MODE_SINGLE) map_regs[IDX_CNTL2] = '0;
        end
        tick_phase = (tick_phase == RATE_LAST) ? 4'd0 : tick_phase + 4'd1;
      end
      default: ;  // unused kind, nothing changes
    endcase
  endtask

  // field reading: extremes, values around the clamp point, small and full-range values
  function automatic sample_t rand_sample();
    int s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 8))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          3: return sample_t'(1);
          4: return sample_t'(-1);
          5: return sample_t'(AXIS_GAIN_DEN);
          6: return sample_t'(-AXIS_GAIN_DEN);
          7: return sample_t'(AXIS_GAIN_DEN + 1);
          default: return sample_t'(-AXIS_GAIN_DEN - 1);
        endcase
      end
      1, 2, 3, 4: begin
        s = int'($urandom_range(0, 140000)) - 70000;
        return sample_t'(s);
      end
      default: return sample_t'($urandom());
    endcase
  endfunction

  // cntl2 value: mostly a known mode with random upper bits, sometimes anything
  function automatic byte_t rand_mode_byte();
    byte_t b;
    b = byte_t'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0: b[4:0] = MODE_SINGLE;
      1: b[4:0] = MODE_DIV10;
      2: b[4:0] = MODE_DIV5;
      3: b[4:0] = MODE_DIV2;
      4, 5: b[4:0] = MODE_EVERY;
      default: ;
    endcase
    return b;
  endfunction

  task automatic push_byte(input logic [1:0] kind, input logic first, input byte_t wdata);
    xact_t t;
    t.kind  = kind;
    t.first = first;
    t.wdata = wdata;
    t.sx    = sample_t'($urandom());
    t.sy    = sample_t'($urandom());
    t.sz    = sample_t'($urandom());
    t.ovf   = 1'($urandom_range(0, 1));
    t.drain = drain_next;
    drain_next = 1'b0;
    pending_xacts.push_back(t);
  endtask

  task automatic push_tick(input sample_t sx, input sample_t sy, input sample_t sz,
                           input logic ovf);
    xact_t t;
    t.kind  = KIND_TICK;
    t.first = 1'($urandom_range(0, 1));
    t.wdata = byte_t'($urandom_range(0, 255));
    t.sx    = sx;
    t.sy    = sy;
    t.sz    = sz;
    t.ovf   = ovf;
    t.drain = drain_next;
    drain_next = 1'b0;
    pending_xacts.push_back(t);
  endtask

  // sender: bursts of transactions with random gaps, driven at the rising edge
  always @(posedge clk) begin : p_driver
    byte_t rd;
    logic  took;
    logic  can_issue;
    int    outstanding;
    if (!rst_n) begin
      start <= 1'b0;
      for (int i = 0; i < NREG; i++) map_regs[i] = '0;
      map_regs[IDX_WIA1] = WIA1_RESET;
      map_regs[IDX_WIA2] = WIA2_RESET;
      map_ptr    = IDX_WIA1;
      map_locked = 1'b0;
      tick_phase = '0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        apply_xact(cur_xact, rd);
        expected_bytes.push_back(rd);
        n_accepted++;
      end
      // a new transaction may go out only when the last one has been taken
      if (!start || took) begin
        // results still owed once this edge is through; n_results is the pre-edge count
        outstanding = n_accepted - n_results - (out_valid ? 1 : 0);
        can_issue = (pending_xacts.size() > 0) && (gap_left == 0);
        if (can_issue && pending_xacts[0].drain && outstanding != 0) can_issue = 1'b0;
        if (gap_left > 0) gap_left--;
        if (can_issue) begin
          cur_xact = pending_xacts.pop_front();
          in_req_type   <= cur_xact.kind;
          in_first_byte <= cur_xact.first;
          in_wdata      <= cur_xact.wdata;
          in_sample_x   <= cur_xact.sx;
          in_sample_y   <= cur_xact.sy;
          in_sample_z   <= cur_xact.sz;
          in_overflow   <= cur_xact.ovf;
          start         <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // new burst: no gap, a short gap or a long gap before the next one, then a new length
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(10, 20);
              default: gap_left = $urandom_range(1, 8);
            endcase
            burst_left = $urandom_range(1, 40);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // receiver: every strobe is taken, compared with the oldest expected byte
  always @(posedge clk) begin : p_monitor
    byte_t want;
    if (rst_n && out_valid) begin
      n_results <= n_results + 1;
      if (expected_bytes.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got rdata %02h",
                 $time, out_rdata);
        n_errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_rdata !== want) begin
          $display("%0t: rdata mismatch, expected %02h, got %02h", $time, want, out_rdata);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles where neither side completes a transaction
  always @(posedge clk) begin : p_watchdog
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_top failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : p_stimulus
    int    total;
    int    target;
    int    n;
    byte_t addr;
    reg_idx_t idx;

    // directed: reset values, dropped and unmapped writes, control chain wrap,
    // single shot with clamping and overflow, lock, overrun, unlock, unused kind, continuous mode
    push_byte(KIND_READ,  1'b0, '0);                  // wia1 reset value
    push_byte(KIND_READ,  1'b0, '0);                  // wia2 reset value
    push_byte(KIND_WRITE, 1'b1, ADDR_WIA1);
    push_byte(KIND_WRITE, 1'b0, 8'hA5);               // read-only, dropped
    push_byte(KIND_WRITE, 1'b1, ADDR_UNMAPPED);       // pointer stays
    push_byte(KIND_WRITE, 1'b1, ADDR_CNTL2);
    push_byte(KIND_WRITE, 1'b0, {3'b000, MODE_SINGLE});
    push_byte(KIND_WRITE, 1'b0, 8'hFF);               // last control reg
    push_byte(KIND_WRITE, 1'b0, 8'h00);               // chain wraps to first control reg
    push_tick(SAMPLE_MAX, SAMPLE_MIN, '0, 1'b1);      // clamped, cntl2 back to zero
    push_byte(KIND_WRITE, 1'b1, ADDR_ST1);
    for (int i = 0; i < 7; i++) push_byte(KIND_READ, 1'b0, '0);  // st1 then data, locks
    push_tick(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 1'b0);          // locked, overrun
    push_byte(KIND_READ,  1'b0, '0);                  // last data byte, lock still held
    push_byte(KIND_READ,  1'b0, '0);                  // st2 releases the lock, pointer wraps to wia1
    push_byte(KIND_UNUSED, 1'b1, 8'hFF);
    push_byte(KIND_WRITE, 1'b1, ADDR_CNTL2);
    push_byte(KIND_WRITE, 1'b0, {3'b111, MODE_EVERY});
    push_tick(SAMPLE_MIN, SAMPLE_MAX, sample_t'(-1), 1'b0);

    // random part: mostly well-formed bus transfers and tick runs
    drain_next = 1'b1;  // pause until the directed results are all back
    target = pending_xacts.size() + RANDOM_XACTS;
    while (pending_xacts.size() < target) begin
      if ($urandom_range(0, 99) < 3) drain_next = 1'b1;
      case ($urandom_range(0, 99)) inside
        [0:14]: begin
          // mode change, sometimes carrying on round the control chain
          push_byte(KIND_WRITE, 1'b1, ADDR_CNTL2);
          push_byte(KIND_WRITE, 1'b0, rand_mode_byte());
          if ($urandom_range(0, 1)) begin
            push_byte(KIND_WRITE, 1'b0, byte_t'($urandom_range(0, 255)));
            push_byte(KIND_WRITE, 1'b0, byte_t'($urandom_range(0, 255)));
          end
        end
        [15:44]: begin
          n = $urandom_range(1, 12);
          repeat (n) push_tick(rand_sample(), rand_sample(), rand_sample(),
                               1'($urandom_range(0, 1)));
        end
        [45:74]: begin
          // data set read up to st2, sometimes cut short to leave the lock held
          addr = ($urandom_range(0, 9) < 7) ? ADDR_ST1
                                            : ADDR_DATA0 + byte_t'($urandom_range(0, 6));
          n = int'(ADDR_ST2 - addr) + 1;
          if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
          else n += $urandom_range(0, 2);
          push_byte(KIND_WRITE, 1'b1, addr);
          repeat (n) push_byte(KIND_READ, 1'b0, '0);
        end
        [75:84]: begin
          idx = reg_idx_t'($urandom_range(0, NREG - 1));
          push_byte(KIND_WRITE, 1'b1, bus_addr(idx));
          n = $urandom_range(1, 16);
          repeat (n) push_byte(KIND_READ, 1'b0, '0);
        end
        [85:94]: begin
          // noise: any kind, any byte, any first flag
          n = $urandom_range(1, 6);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0: push_byte(KIND_WRITE, 1'($urandom_range(0, 1)),
                           byte_t'($urandom_range(0, 255)));
              1: push_byte(KIND_READ, 1'($urandom_range(0, 1)),
                           byte_t'($urandom_range(0, 255)));
              2: push_tick(sample_t'($urandom()), sample_t'($urandom()),
                           sample_t'($urandom()), 1'($urandom_range(0, 1)));
              default: push_byte(KIND_UNUSED, 1'($urandom_range(0, 1)),
                                 byte_t'($urandom_range(0, 255)));
            endcase
          end
        end
        default: begin
          // raw control register writes
          addr = ADDR_CTRL_A + byte_t'($urandom_range(0, 2));
          push_byte(KIND_WRITE, 1'b1, addr);
          n = $urandom_range(1, 4);
          repeat (n) push_byte(KIND_WRITE, 1'b0, byte_t'($urandom_range(0, 255)));
        end
      endcase
    end
    total = pending_xacts.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every result, then give the block time to show anything stray
    while (n_results < total) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_bytes.size());
      n_errors++;
    end

    $display("run: %0d transactions (%0d writes, %0d reads, %0d ticks), %0d results checked",
             n_accepted, n_writes, n_reads, n_ticks, n_results);
    $display("run: %0d data updates, %0d data locks, %0d overruns, %0d mismatches",
             n_updates, n_locks, n_overruns, n_errors);
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
